/* rtl/dabt_pkg.sv */
// ---------------------------------------------------------------------------
// dabt_pkg
// Types and constants shared by the admission table files.
// ---------------------------------------------------------------------------
package dabt_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int HASH_SLOTS_DEF  = 512;

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int          MIX_SHIFT = 33;

	localparam logic [1:0] OP_RESERVE  = 2'd0;
	localparam logic [1:0] OP_CONTAINS = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;

	localparam logic [2:0] DEC_RESERVED    = 3'd0;
	localparam logic [2:0] DEC_DUPLICATE   = 3'd1;
	localparam logic [2:0] DEC_ENTRY_LIMIT = 3'd2;
	localparam logic [2:0] DEC_BYTE_LIMIT  = 3'd3;
	localparam logic [2:0] DEC_UNAVAILABLE = 3'd4;

	localparam logic REG_BYTE_LIMIT  = 1'b0;
	localparam logic REG_ENTRY_LIMIT = 1'b1;

	// item handed from the hash front to the table back
	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] key;
		logic [31:0] charge;
		logic [63:0] hash;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLRSWEEP, ST_RDSLOT, ST_WAITSLOT, ST_CHKSLOT,
		ST_WAITKEY, ST_CHKKEY, ST_DECIDE, ST_OUT, ST_INITCLR
	} back_state_t;

	typedef enum logic [2:0] {
		FS_IDLE, FS_M1, FS_M1B, FS_M2, FS_M2B, FS_DONE
	} front_state_t;

endpackage

/* rtl/dabt_if.sv */
// ---------------------------------------------------------------------------
// dabt_in_if / dabt_out_if
// Valid/ready channels for items and results.
// ---------------------------------------------------------------------------
interface dabt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] key;
	logic [31:0] charge_bytes;
	modport source (output valid, op, key, charge_bytes, input ready);
	modport sink (input valid, op, key, charge_bytes, output ready);
endinterface

interface dabt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  decision;
	logic        found;
	logic [31:0] total_charged;
	logic [8:0]  entries_seen;
	logic [31:0] reserved_count;
	logic [31:0] duplicate_count;
	logic [31:0] entry_skip_count;
	logic [31:0] byte_skip_count;
	logic [31:0] unavailable_count;
	modport source (output valid, decision, found, total_charged, entries_seen,
		reserved_count, duplicate_count, entry_skip_count, byte_skip_count,
		unavailable_count, input ready);
	modport sink (input valid, decision, found, total_charged, entries_seen,
		reserved_count, duplicate_count, entry_skip_count, byte_skip_count,
		unavailable_count, output ready);
endinterface

/* rtl/dabt_ram.sv */
// ---------------------------------------------------------------------------
// dabt_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module dabt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/dabt_front.sv */
// ---------------------------------------------------------------------------
// dabt_front
// Accepts items and computes the murmur finalizer hash. Each 64x64 product
// keeps its low 64 bits from three 32x32 partial products.
// ---------------------------------------------------------------------------
module dabt_front (
	input  logic          clk,
	input  logic          arst_n,
	dabt_in_if.sink       in_ch,
	output logic          job_valid,
	input  logic          job_ready,
	output dabt_pkg::job_t job
);
	dabt_pkg::front_state_t state_q;
	logic [1:0]  op_q;
	logic [63:0] key_q, h_q, cst_q;
	logic [31:0] charge_q;
	logic [63:0] lo_q, mid_q;
	logic [63:0] mul_a, mul_b;

	assign in_ch.ready = (state_q == dabt_pkg::FS_IDLE);
	assign job_valid   = (state_q == dabt_pkg::FS_DONE);
	assign job.op      = op_q;
	assign job.key     = key_q;
	assign job.charge  = charge_q;
	assign job.hash    = h_q;

	// low-half partial products, registered
	assign mul_a = 64'(h_q[31:0]) * 64'(cst_q[31:0]);
	assign mul_b = 64'(h_q[31:0]) * 64'(cst_q[63:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dabt_pkg::FS_IDLE;
		end else begin
			case (state_q)
				dabt_pkg::FS_IDLE: if (in_ch.valid) state_q <= dabt_pkg::FS_M1;
				dabt_pkg::FS_M1:   state_q <= dabt_pkg::FS_M1B;
				dabt_pkg::FS_M1B:  state_q <= dabt_pkg::FS_M2;
				dabt_pkg::FS_M2:   state_q <= dabt_pkg::FS_M2B;
				dabt_pkg::FS_M2B:  state_q <= dabt_pkg::FS_DONE;
				dabt_pkg::FS_DONE: if (job_ready) state_q <= dabt_pkg::FS_IDLE;
				default:           state_q <= dabt_pkg::FS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dabt_pkg::FS_IDLE: begin
				op_q     <= in_ch.op;
				key_q    <= in_ch.key;
				charge_q <= in_ch.charge_bytes;
				h_q      <= in_ch.key ^ (in_ch.key >> dabt_pkg::MIX_SHIFT);
				cst_q    <= dabt_pkg::MIX_C1;
			end
			dabt_pkg::FS_M1, dabt_pkg::FS_M2: begin
				lo_q  <= mul_a;
				mid_q <= mul_b;
			end
			dabt_pkg::FS_M1B, dabt_pkg::FS_M2B: begin
				// add the cross term h_hi*c_lo, then shift-xor
				h_q <= ({lo_q[63:32] + mid_q[31:0]
					+ 32'(h_q[63:32] * cst_q[31:0]), lo_q[31:0]})
					^ ({lo_q[63:32] + mid_q[31:0]
					+ 32'(h_q[63:32] * cst_q[31:0]), lo_q[31:0]}
					>> dabt_pkg::MIX_SHIFT);
				cst_q <= dabt_pkg::MIX_C2;
			end
			default: ;
		endcase
	end
endmodule

/* rtl/dabt_queue.sv */
// ---------------------------------------------------------------------------
// dabt_queue
// Two-entry queue between the hash front and the table back.
// ---------------------------------------------------------------------------
module dabt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  dabt_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output dabt_pkg::job_t pop_data
);
	dabt_pkg::job_t buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = buf_q[rp_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= push_data;
	end
endmodule

/* rtl/dabt_back.sv */
// ---------------------------------------------------------------------------
// dabt_back
// Probes the slot table, applies the admission rules, updates counters and
// holds the result register. Slot table and key store sit in RAMs.
// ---------------------------------------------------------------------------
module dabt_back #(
	parameter int MAX_ENTRIES = dabt_pkg::MAX_ENTRIES_DEF,
	parameter int HASH_SLOTS  = dabt_pkg::HASH_SLOTS_DEF,
	localparam int SW = $clog2(HASH_SLOTS),
	localparam int EW = $clog2(MAX_ENTRIES + 1),
	localparam int KW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           job_valid,
	output logic           job_ready,
	input  dabt_pkg::job_t job,
	dabt_out_if.source     out_ch
);
	localparam int CW = SW + 1;
	localparam logic [SW-1:0] SLOT_LAST = SW'(HASH_SLOTS - 1);
	localparam logic [CW-1:0] SLOT_NUM  = CW'(HASH_SLOTS);
	localparam logic [EW-1:0] ENT_MAX   = EW'(MAX_ENTRIES);

	dabt_pkg::back_state_t state_q;
	logic [31:0] byte_limit_q;
	logic [8:0]  entry_limit_q;
	logic [1:0]  op_q;
	logic [63:0] key_q;
	logic [31:0] charge_q;
	logic [SW-1:0] slot_q;
	logic [CW-1:0] probes_q;
	logic [EW-1:0] seen_q;
	logic          hit_q, full_q;
	logic [31:0] total_q, res_q, dup_q, eskip_q, bskip_q, unav_q;
	logic [2:0]  dec_q;
	logic        found_q;

	logic          s_we;
	logic [SW-1:0] s_waddr, s_raddr;
	logic [EW-1:0] s_wdata, s_rdata;
	logic          k_we;
	logic [KW-1:0] k_waddr, k_raddr;
	logic [63:0]   k_rdata;
	logic [SW-1:0] start_slot;
	logic [EW-1:0] lim;
	logic [EW-1:0] vm1;

	dabt_ram #(.WIDTH(EW), .DEPTH(HASH_SLOTS)) u_slots (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));
	dabt_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(key_q),
		.raddr(k_raddr), .rdata(k_rdata));

	// power-of-two slot count masks; otherwise reduce 64-bit hash by constant
	assign start_slot = SW'(job.hash % 64'(HASH_SLOTS));
	assign lim = ({23'd0, entry_limit_q} < 32'(MAX_ENTRIES))
		? EW'(entry_limit_q) : ENT_MAX;
	assign vm1 = s_rdata - EW'(1);
	assign s_raddr = slot_q;
	assign k_raddr = KW'(vm1);
	assign job_ready = (state_q == dabt_pkg::ST_IDLE);

	always_comb begin
		s_we    = 1'b0;
		s_waddr = slot_q;
		s_wdata = seen_q + EW'(1);
		k_we    = 1'b0;
		k_waddr = KW'(seen_q);
		if (state_q == dabt_pkg::ST_CLRSWEEP || state_q == dabt_pkg::ST_INITCLR) begin
			s_we    = 1'b1;
			s_wdata = '0;
		end else if (state_q == dabt_pkg::ST_DECIDE && op_q == dabt_pkg::OP_RESERVE
				&& !hit_q && !full_q && seen_q < lim) begin
			s_we = 1'b1;
			k_we = 1'b1;
		end
	end

	assign out_ch.valid             = (state_q == dabt_pkg::ST_OUT);
	assign out_ch.decision          = dec_q;
	assign out_ch.found             = found_q;
	assign out_ch.total_charged     = total_q;
	assign out_ch.entries_seen      = 9'(seen_q);
	assign out_ch.reserved_count    = res_q;
	assign out_ch.duplicate_count   = dup_q;
	assign out_ch.entry_skip_count  = eskip_q;
	assign out_ch.byte_skip_count   = bskip_q;
	assign out_ch.unavailable_count = unav_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= dabt_pkg::ST_INITCLR;
			slot_q        <= '0;
			byte_limit_q  <= '0;
			entry_limit_q <= '0;
			seen_q <= '0; total_q <= '0; res_q <= '0; dup_q <= '0;
			eskip_q <= '0; bskip_q <= '0; unav_q <= '0;
			probes_q <= '0; hit_q <= 1'b0; full_q <= 1'b0;
			dec_q <= '0; found_q <= 1'b0; op_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == dabt_pkg::REG_BYTE_LIMIT) byte_limit_q <= cfg_data;
				else entry_limit_q <= cfg_data[8:0];
			end
			case (state_q)
				dabt_pkg::ST_INITCLR, dabt_pkg::ST_CLRSWEEP: begin
					slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SW'(1);
					if (slot_q == SLOT_LAST)
						state_q <= (state_q == dabt_pkg::ST_INITCLR)
							? dabt_pkg::ST_IDLE : dabt_pkg::ST_OUT;
				end
				dabt_pkg::ST_IDLE: if (job_valid) begin
					op_q     <= job.op;
					key_q    <= job.key;
					charge_q <= job.charge;
					probes_q <= '0;
					hit_q    <= 1'b0;
					full_q   <= 1'b0;
					dec_q    <= dabt_pkg::DEC_RESERVED;
					found_q  <= 1'b0;
					if (job.op == dabt_pkg::OP_CLEAR) begin
						seen_q <= '0; total_q <= '0; res_q <= '0; dup_q <= '0;
						eskip_q <= '0; bskip_q <= '0; unav_q <= '0;
						slot_q  <= '0;
						state_q <= dabt_pkg::ST_CLRSWEEP;
					end else if (job.op == dabt_pkg::OP_RESERVE
							|| job.op == dabt_pkg::OP_CONTAINS) begin
						slot_q  <= start_slot;
						state_q <= dabt_pkg::ST_WAITSLOT;
					end else begin
						state_q <= dabt_pkg::ST_OUT;
					end
				end
				dabt_pkg::ST_RDSLOT:   state_q <= dabt_pkg::ST_WAITSLOT;
				dabt_pkg::ST_WAITSLOT: state_q <= dabt_pkg::ST_CHKSLOT;
				dabt_pkg::ST_CHKSLOT: begin
					if (s_rdata == '0) begin
						state_q <= dabt_pkg::ST_DECIDE;
					end else if (vm1 < seen_q) begin
						state_q <= dabt_pkg::ST_WAITKEY;
					end else if (probes_q == SLOT_NUM - CW'(1)) begin
						full_q  <= 1'b1;
						state_q <= dabt_pkg::ST_DECIDE;
					end else begin
						probes_q <= probes_q + CW'(1);
						slot_q   <= (slot_q == SLOT_LAST) ? '0 : slot_q + SW'(1);
						state_q  <= dabt_pkg::ST_RDSLOT;
					end
				end
				dabt_pkg::ST_WAITKEY: state_q <= dabt_pkg::ST_CHKKEY;
				dabt_pkg::ST_CHKKEY: begin
					if (k_rdata == key_q) begin
						hit_q   <= 1'b1;
						state_q <= dabt_pkg::ST_DECIDE;
					end else if (probes_q == SLOT_NUM - CW'(1)) begin
						full_q  <= 1'b1;
						state_q <= dabt_pkg::ST_DECIDE;
					end else begin
						probes_q <= probes_q + CW'(1);
						slot_q   <= (slot_q == SLOT_LAST) ? '0 : slot_q + SW'(1);
						state_q  <= dabt_pkg::ST_RDSLOT;
					end
				end
				dabt_pkg::ST_DECIDE: begin
					state_q <= dabt_pkg::ST_OUT;
					found_q <= hit_q;
					if (op_q == dabt_pkg::OP_RESERVE) begin
						if (hit_q) begin
							dec_q <= dabt_pkg::DEC_DUPLICATE;
							dup_q <= dup_q + 32'd1;
						end else if (full_q || seen_q >= lim) begin
							dec_q   <= dabt_pkg::DEC_ENTRY_LIMIT;
							eskip_q <= eskip_q + 32'd1;
						end else begin
							seen_q <= seen_q + EW'(1);
							if (charge_q == '0) begin
								dec_q  <= dabt_pkg::DEC_UNAVAILABLE;
								unav_q <= unav_q + 32'd1;
							end else if (total_q > byte_limit_q
									|| charge_q > byte_limit_q - total_q) begin
								dec_q   <= dabt_pkg::DEC_BYTE_LIMIT;
								bskip_q <= bskip_q + 32'd1;
							end else begin
								dec_q   <= dabt_pkg::DEC_RESERVED;
								total_q <= total_q + charge_q;
								res_q   <= res_q + 32'd1;
							end
						end
					end
				end
				dabt_pkg::ST_OUT: if (out_ch.ready) state_q <= dabt_pkg::ST_IDLE;
				default: state_q <= dabt_pkg::ST_IDLE;
			endcase
		end
	end
endmodule

/* rtl/dedup_admission_budget_table.sv */
// ---------------------------------------------------------------------------
// dedup_admission_budget_table
// Key deduplication table with entry and byte budgets.
// ---------------------------------------------------------------------------
// The front takes an item, runs the two split 64-bit multiplies of the hash
// through FS_M1, FS_M1B, FS_M2 and FS_M2B and hands it to the two-entry queue
// from FS_DONE once the queue has room; it takes no new item until then. The
// back takes an item from the queue in ST_IDLE and probes the slot RAM by
// linear probing: ST_WAITSLOT and ST_CHKSLOT for the start slot, ST_RDSLOT,
// ST_WAITSLOT and ST_CHKSLOT for each further slot, and ST_WAITKEY and
// ST_CHKKEY for every occupied slot whose key is read and compared; ST_DECIDE
// decides and ST_OUT holds the result until ready. Front and back overlap, so
// the slower of the two sets the rate. Clear sweeps every slot of the slot
// RAM; after reset the same sweep runs over all HASH_SLOTS slots before the
// back takes the first item.
module dedup_admission_budget_table #(
	parameter int MAX_ENTRIES = dabt_pkg::MAX_ENTRIES_DEF,
	parameter int HASH_SLOTS  = dabt_pkg::HASH_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	dabt_in_if.sink     in_ch,
	dabt_out_if.source  out_ch
);
	logic           f_valid, f_ready, q_valid, q_ready;
	dabt_pkg::job_t f_job, q_job;

	dabt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job));

	dabt_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_job),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_job));

	dabt_back #(.MAX_ENTRIES(MAX_ENTRIES), .HASH_SLOTS(HASH_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.out_ch(out_ch));
endmodule
